[design/odm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// odm_pkg
// Shared types and constants of the X-drive mixer and PWM duty block.
// ----------------------------------------------------------------------------
package odm_pkg;

    localparam int NUM_LANES = 4;
    localparam int PWR_W     = 20;          // signed working width of a wheel power
    localparam int PROD_W    = 33;          // signed width of the mixing product

    // Request kinds carried in tuser
    typedef enum logic [1:0] {
        REQ_TICK   = 2'd0,
        REQ_VECTOR = 2'd1,
        REQ_DIRECT = 2'd2
    } t_req;

    // Register indexes of the configuration port
    localparam logic [1:0] CFG_INVERT_MASK = 2'd0;
    localparam logic [1:0] CFG_MIN_POWER   = 2'd1;
    localparam logic [1:0] CFG_MAX_POWER   = 2'd2;
    localparam logic [1:0] CFG_IDLE_TMO    = 2'd3;

    // 0.7071 in Q1.15
    localparam logic signed [15:0] MIX_COEF  = 16'sd23170;
    localparam logic signed [32:0] RND_HALF  = 33'sd16384;
    localparam logic [15:0]        HALF_DUTY = 16'd25600;
    localparam logic [15:0]        FULL_DUTY = 16'd51200;

    // Per-wheel signs on x and y: m1 (-x -y), m2 (+x -y), m3 (+x +y), m4 (-x +y)
    localparam logic [NUM_LANES-1:0] LANE_X_NEG = 4'b1001;
    localparam logic [NUM_LANES-1:0] LANE_Y_NEG = 4'b0011;

    typedef struct packed {
        logic x_neg;
        logic y_neg;
        logic invert;
    } t_lane_ctl;

    typedef struct packed {
        logic [14:0] min_power;
        logic [14:0] max_power;
    } t_limits;

endpackage : odm_pkg
`default_nettype wire

[design/omni_drive_mixer_pwm_duty.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// omni_drive_mixer_pwm_duty
// Four-wheel X-drive mixer: motion vectors or direct powers in, PWM duties out.
// ----------------------------------------------------------------------------
// Pipeline: a command item accepted on the slave side is loaded into the multiply
//   stage, then the power stage, then the result register, from which it is
//   offered on the master side.
// Throughput: one item per cycle; each of the four wheel lanes holds one
//   multiplier, and the single result register lets a held result stall the lanes.
// Reset (synchronous, active low): pipeline and result emptied, idle count zero,
//   registers back to invert 0, min 2560, max 25600, timeout 300 ms.
// ----------------------------------------------------------------------------
module omni_drive_mixer_pwm_duty import odm_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // slave side
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [15:0] vec_x, [31:16] vec_y, [47:32] turn, [63:48] power_1,
    // [79:64] power_2, [95:80] power_3, [111:96] power_4
    input  wire logic [111:0] s_axis_tdata,
    // [1:0] req_type
    input  wire logic [1:0]   s_axis_tuser,
    // master side
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [15:0] duty_1, [31:16] duty_2, [47:32] duty_3, [63:48] duty_4,
    // [64] driver_awake, [71:65] zero
    output logic [71:0]       m_axis_tdata,
    // configuration
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_addr,
    input  wire logic [15:0]  i_cfg_wdata
);

    // configuration registers
    logic [NUM_LANES-1:0] r_invert_mask;
    logic [14:0]          r_min_power;
    logic [14:0]          r_max_power;
    logic [15:0]          r_idle_tmo;

    // pipeline control: valid and request kind per stage
    logic                 r_v1;
    t_req                 r_k1;
    logic                 r_v2;
    t_req                 r_k2;

    logic                 adv;
    logic                 accept;
    logic                 kind_ok;
    t_req                 in_kind;
    t_limits              limits;

    logic [NUM_LANES-1:0]       lane_zero;
    logic [NUM_LANES-1:0][15:0] lane_duty;
    logic [NUM_LANES-1:0][15:0] out_duty;
    logic                       out_awake;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invert_mask <= '0;
            r_min_power   <= 15'd2560;
            r_max_power   <= 15'd25600;
            r_idle_tmo    <= 16'd300;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_INVERT_MASK: r_invert_mask <= i_cfg_wdata[NUM_LANES-1:0];
                CFG_MIN_POWER:   r_min_power   <= i_cfg_wdata[14:0];
                CFG_MAX_POWER:   r_max_power   <= i_cfg_wdata[14:0];
                CFG_IDLE_TMO:    r_idle_tmo    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Decode the request; the unused code is taken and dropped at once.
    always_comb begin
        in_kind = t_req'(s_axis_tuser);
        case (in_kind)
            REQ_TICK, REQ_VECTOR, REQ_DIRECT: kind_ok = 1'b1;
            default:                          kind_ok = 1'b0;
        endcase
    end

    assign s_axis_tready = adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Ticks travel the pipeline too, so the idle count sees every item in order.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (adv) begin
            r_v1 <= accept && kind_ok;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_k1 <= in_kind;
            r_k2 <= r_k1;
        end
    end

    assign limits.min_power = r_min_power;
    assign limits.max_power = r_max_power;

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        t_lane_ctl ctl;

        assign ctl.x_neg  = LANE_X_NEG[g];
        assign ctl.y_neg  = LANE_Y_NEG[g];
        assign ctl.invert = r_invert_mask[g];

        odm_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (adv),
            .i_ctl    (ctl),
            .i_lim    (limits),
            .i_direct (in_kind == REQ_DIRECT),
            .i_x      (s_axis_tdata[15:0]),
            .i_y      (s_axis_tdata[31:16]),
            .i_turn   (s_axis_tdata[47:32]),
            .i_power  (s_axis_tdata[48+16*g +: 16]),
            .o_zero   (lane_zero[g]),
            .o_duty   (lane_duty[g])
        );
    end

    // Merge the lanes: all-zero check, idle counter, result register.
    odm_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_v2),
        .i_kind      (r_k2),
        .i_zero      (lane_zero),
        .i_duty      (lane_duty),
        .i_timeout   (r_idle_tmo),
        .i_out_ready (m_axis_tready),
        .o_adv       (adv),
        .o_out_valid (m_axis_tvalid),
        .o_duty      (out_duty),
        .o_awake     (out_awake)
    );

    assign m_axis_tdata = {7'b0, out_awake, out_duty[3], out_duty[2], out_duty[1], out_duty[0]};

endmodule : omni_drive_mixer_pwm_duty
`default_nettype wire

[design/odm_lane.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// odm_lane
// One wheel: mix the vector into a power or take the direct power, invert, clamp and form the duty.
// ----------------------------------------------------------------------------
module odm_lane import odm_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire t_lane_ctl          i_ctl,
    input  wire t_limits            i_lim,
    input  wire logic               i_direct,
    input  wire logic signed [15:0] i_x,
    input  wire logic signed [15:0] i_y,
    input  wire logic signed [15:0] i_turn,
    input  wire logic signed [15:0] i_power,
    output logic                    o_zero,
    output logic [15:0]             o_duty
);

    logic signed [PROD_W-1:0] r_prod;
    logic signed [15:0]       r_base;
    logic                     r_direct;
    logic signed [PWR_W-1:0]  r_pwr;

    logic signed [17:0]       sx;
    logic signed [17:0]       sy;
    logic signed [17:0]       ssum;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [PROD_W-1:0] rsum;
    logic signed [17:0]       rnd;
    logic signed [PWR_W-1:0]  mixed;
    logic signed [PWR_W-1:0]  n_pwr;
    logic signed [PWR_W-1:0]  lim_max;
    logic signed [PWR_W-1:0]  lim_min;
    logic signed [PWR_W-1:0]  clamped;
    logic signed [20:0]       duty_raw;

    // stage 1: signed sum of x and y, scaled by the coefficient
    always_comb begin
        sx     = i_ctl.x_neg ? -18'(i_x) : 18'(i_x);
        sy     = i_ctl.y_neg ? -18'(i_y) : 18'(i_y);
        ssum   = sx + sy;
        n_prod = PROD_W'(ssum) * PROD_W'(MIX_COEF);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod   <= n_prod;
            r_base   <= i_direct ? i_power : i_turn;
            r_direct <= i_direct;
        end
    end

    // stage 2: round to nearest (ties up), add turn or take the direct power, optionally invert
    always_comb begin
        rsum  = r_prod + RND_HALF;
        rnd   = 18'(rsum >>> 15);
        mixed = r_direct ? PWR_W'(r_base) : PWR_W'(rnd) + PWR_W'(r_base);
        n_pwr = i_ctl.invert ? -mixed : mixed;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pwr <= n_pwr;
        end
    end

    // clamp magnitude (upper bound first), then offset to the duty scale
    always_comb begin
        lim_max = PWR_W'({1'b0, i_lim.max_power});
        lim_min = PWR_W'({1'b0, i_lim.min_power});
        clamped = r_pwr;
        if (r_pwr > 0) begin
            if (r_pwr > lim_max) begin
                clamped = lim_max;
            end else if (r_pwr < lim_min) begin
                clamped = lim_min;
            end
        end else if (r_pwr < 0) begin
            if (r_pwr < -lim_max) begin
                clamped = -lim_max;
            end else if (r_pwr > -lim_min) begin
                clamped = -lim_min;
            end
        end
        duty_raw = 21'(clamped) + 21'($signed({1'b0, HALF_DUTY}));
        if (duty_raw < 0) begin
            o_duty = '0;
        end else if (duty_raw > 21'($signed({1'b0, FULL_DUTY}))) begin
            o_duty = FULL_DUTY;
        end else begin
            o_duty = 16'(duty_raw);
        end
        o_zero = (r_pwr == '0);
    end

endmodule : odm_lane
`default_nettype wire

[design/odm_merge.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// odm_merge
// Combine the four lanes, keep the idle counter and hold the result item.
// ----------------------------------------------------------------------------
module odm_merge import odm_pkg::*; (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire t_req                        i_kind,
    input  wire logic [NUM_LANES-1:0]        i_zero,
    input  wire logic [NUM_LANES-1:0][15:0]  i_duty,
    input  wire logic [15:0]                 i_timeout,
    input  wire logic                        i_out_ready,
    output logic                             o_adv,
    output logic                             o_out_valid,
    output logic [NUM_LANES-1:0][15:0]       o_duty,
    output logic                             o_awake
);

    logic                            r_out_valid;
    logic [NUM_LANES-1:0][15:0]      r_duty;
    logic                            r_awake;
    logic [15:0]                     r_idle_ms;

    logic                            n_out_valid;
    logic [NUM_LANES-1:0][15:0]      n_duty;
    logic                            n_awake;
    logic [15:0]                     n_idle_ms;
    logic                            all_zero;
    logic                            is_cmd;

    assign o_adv = !r_out_valid || i_out_ready;

    always_comb begin
        all_zero    = &i_zero;
        is_cmd      = (i_kind != REQ_TICK);
        n_out_valid = i_valid && is_cmd;
        n_idle_ms   = r_idle_ms;
        if (i_valid) begin
            if (!is_cmd) begin
                if (r_idle_ms != '1) begin
                    n_idle_ms = r_idle_ms + 16'd1;
                end
            end else if (!all_zero) begin
                n_idle_ms = '0;
            end
        end
        if (all_zero) begin
            for (int i = 0; i < NUM_LANES; i++) begin
                n_duty[i] = HALF_DUTY;
            end
            n_awake = !(r_idle_ms > i_timeout);
        end else begin
            n_duty  = i_duty;
            n_awake = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idle_ms   <= '0;
        end else if (o_adv) begin
            r_out_valid <= n_out_valid;
            r_idle_ms   <= n_idle_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && n_out_valid) begin
            r_duty  <= n_duty;
            r_awake <= n_awake;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_duty      = r_duty;
    assign o_awake     = r_awake;

    // a sleeping driver only ever comes with half-period duties
    a_sleep_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_awake) |->
            (r_duty[0] == HALF_DUTY && r_duty[1] == HALF_DUTY &&
             r_duty[2] == HALF_DUTY && r_duty[3] == HALF_DUTY))
        else $error("sleep with non-neutral duty");

    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_duty[0] <= FULL_DUTY && r_duty[1] <= FULL_DUTY &&
                         r_duty[2] <= FULL_DUTY && r_duty[3] <= FULL_DUTY))
        else $error("duty beyond full scale");

    a_cmd_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_adv && i_valid && i_kind != REQ_TICK) |=> r_out_valid)
        else $error("command item lost");

    a_tick_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_adv && (!i_valid || i_kind == REQ_TICK)) |=> !r_out_valid)
        else $error("result without a command");

endmodule : odm_merge
`default_nettype wire
